// ===== sv/csort_pkg.sv =====
// Shared types, constants and codes for the counting sort engine.
package csort_pkg;

  localparam int NUM_BUCKETS_DEF = 128;
  localparam int MAX_ITEMS_DEF   = 65535;

  localparam int KEY_W    = 7;
  localparam int VALUE_W  = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DROP  = 2'd2;

  localparam logic ALU_INC = 1'b0;
  localparam logic ALU_DEC = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

// ===== sv/csort_alu.sv =====
// Shared count unit: increment or decrement of one bucket count with limit flags.
module csort_alu (
  input  logic                          op,
  input  logic [csort_pkg::COUNT_W-1:0] cnt_in,
  output logic [csort_pkg::COUNT_W-1:0] cnt_out,
  output logic                          at_max,
  output logic                          is_zero
);
  import csort_pkg::*;

  always_comb begin
    at_max  = (cnt_in == COUNT_MAX);
    is_zero = (cnt_in == '0);
    if (op == ALU_INC) begin
      cnt_out = cnt_in + COUNT_W'(1);
    end else begin
      cnt_out = cnt_in - COUNT_W'(1);
    end
  end

endmodule

// ===== sv/csort_ram.sv =====
// Bucket count memory: one write port, one registered read port.
module csort_ram #(
  parameter int NUM_BUCKETS = csort_pkg::NUM_BUCKETS_DEF,
  parameter int PTR_W       = $clog2(NUM_BUCKETS)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [PTR_W-1:0]              waddr,
  input  logic [csort_pkg::COUNT_W-1:0] wdata,
  input  logic [PTR_W-1:0]              raddr,
  output logic [csort_pkg::COUNT_W-1:0] rdata
);
  import csort_pkg::*;

  logic [COUNT_W-1:0] mem [NUM_BUCKETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/csort_ctrl.sv =====
// Sequencer: clearing pass, insert read-modify-write, take walk over buckets.
module csort_ctrl #(
  parameter int NUM_BUCKETS = csort_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_ITEMS   = csort_pkg::MAX_ITEMS_DEF,
  parameter int PTR_W       = $clog2(NUM_BUCKETS),
  parameter int ITEM_W      = $clog2(MAX_ITEMS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [csort_pkg::KEY_W-1:0]   in_key,
  input  logic                          out_free,
  output logic                          res_valid,
  output csort_pkg::result_t            res,
  output logic                          mem_we,
  output logic [PTR_W-1:0]              mem_waddr,
  output logic [csort_pkg::COUNT_W-1:0] mem_wdata,
  output logic [PTR_W-1:0]              mem_raddr,
  input  logic [csort_pkg::COUNT_W-1:0] mem_rdata
);
  import csort_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_TAKE  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  localparam logic [PTR_W-1:0]  LAST_BUCKET = PTR_W'(NUM_BUCKETS - 1);
  localparam logic [ITEM_W-1:0] ITEMS_FULL  = ITEM_W'(MAX_ITEMS);

  logic [2:0]         state;
  logic [PTR_W-1:0]   clr_addr;
  logic [PTR_W-1:0]   ptr;
  logic [PTR_W-1:0]   walk;
  logic [PTR_W-1:0]   ins_key;
  logic [ITEM_W-1:0]  items;
  logic [PTR_W-1:0]   k_sat;
  logic               alu_op;
  logic [COUNT_W-1:0] cnt_out;
  logic               at_max;
  logic               is_zero;

  csort_alu u_alu (
    .op      (alu_op),
    .cnt_in  (mem_rdata),
    .cnt_out (cnt_out),
    .at_max  (at_max),
    .is_zero (is_zero)
  );

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESP) && out_free;
  assign alu_op    = (state == ST_INS) ? ALU_INC : ALU_DEC;

  always_comb begin
    if (int'(in_key) >= NUM_BUCKETS) begin
      k_sat = LAST_BUCKET;
    end else begin
      k_sat = PTR_W'(in_key);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk;
    mem_wdata = cnt_out;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_INS: begin
        mem_we    = !at_max;
        mem_waddr = ins_key;
      end
      ST_TAKE: begin
        mem_we    = !is_zero;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
    case (state)
      ST_IDLE:  mem_raddr = (in_op == OP_TAKE) ? ptr : k_sat;
      ST_TAKE:  mem_raddr = walk + PTR_W'(1);
      default:  mem_raddr = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      items    <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + PTR_W'(1);
          if (clr_addr == LAST_BUCKET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (in_op == OP_INSERT) begin
              if (items == ITEMS_FULL) begin
                res   <= '{value: '0, status: STAT_DROP, last: 1'b0};
                state <= ST_RESP;
              end else begin
                ins_key <= k_sat;
                state   <= ST_INS;
              end
            end else begin
              if (items == '0) begin
                res   <= '{value: '0, status: STAT_EMPTY, last: 1'b0};
                state <= ST_RESP;
              end else begin
                walk  <= ptr;
                state <= ST_TAKE;
              end
            end
          end
        end
        ST_INS: begin
          if (at_max) begin
            res <= '{value: '0, status: STAT_DROP, last: 1'b0};
          end else begin
            items <= items + ITEM_W'(1);
            if (ins_key < ptr) begin
              ptr <= ins_key;
            end
            res <= '{value: '0, status: STAT_DONE, last: 1'b0};
          end
          state <= ST_RESP;
        end
        ST_TAKE: begin
          if (is_zero) begin
            if (walk == LAST_BUCKET) begin
              res   <= '{value: '0, status: STAT_EMPTY, last: 1'b0};
              state <= ST_RESP;
            end else begin
              walk <= walk + PTR_W'(1);
            end
          end else begin
            ptr   <= walk;
            items <= items - ITEM_W'(1);
            res   <= '{value: VALUE_W'(walk), status: STAT_DONE,
                       last: (items == ITEM_W'(1))};
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_items_bound: assert property (@(posedge clk) disable iff (rst)
    items <= ITEMS_FULL)
    else $error("item count above capacity");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready && !res_valid)
    else $error("beat taken during clearing pass");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |-> (res.status == STAT_DONE) && (items == '0))
    else $error("last flag without emptied store");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAKE) |-> (items != '0))
    else $error("walk started on empty store");
`endif

endmodule

// ===== sv/counting_sort_engine_core.sv =====
// Top level of the counting sort engine: sequencer, count memory, output register.
//
//  channel   dir  tdata (low bit up)      tuser (low bit up)   tlast
//  s_axis    in   key[6:0], pad[7]        operation[0]         -
//  m_axis    out  value[6:0], pad[7]      status[1:0]          last
//
//  After reset a clearing pass writes zero to all NUM_BUCKETS counts; s_axis_tready is low.
//  Insert: ST_INS increments and writes back the count, then ST_RESP loads the output register.
//  Take: ST_TAKE walks from the scan pointer over empty buckets, then ST_RESP loads the output register.
//  Take on empty store or insert when full: straight to ST_RESP; every case then returns to ST_IDLE.
//  One item at a time; a stalled m_axis holds the result and the next beat waits.
module counting_sort_engine_core #(
  parameter int NUM_BUCKETS = csort_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_ITEMS   = csort_pkg::MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // key[6:0], zero pad
  input  logic [0:0] s_axis_tuser,   // operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // value[6:0], zero pad
  output logic [1:0] m_axis_tuser,   // status
  output logic       m_axis_tlast    // last
);
  import csort_pkg::*;

  localparam int PTR_W  = $clog2(NUM_BUCKETS);
  localparam int ITEM_W = $clog2(MAX_ITEMS + 1);

  logic               out_free;
  logic               res_valid;
  result_t            res;
  result_t            out_reg;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic [PTR_W-1:0]   mem_raddr;
  logic [COUNT_W-1:0] mem_rdata;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  csort_ctrl #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .MAX_ITEMS   (MAX_ITEMS),
    .PTR_W       (PTR_W),
    .ITEM_W      (ITEM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser[0]),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  csort_ram #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .PTR_W       (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_reg.value};
  assign m_axis_tuser = out_reg.status;
  assign m_axis_tlast = out_reg.last;

`ifndef ASSERT_OFF
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote pending beat");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != STAT_DONE)) |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("nonzero value on failed beat");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while busy");
`endif

endmodule
